[rtl/core/assert_macros.svh]
// assertion macros shared by the shoebox ray wall hit rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SRWH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("srwh assertion failed");
`define SRWH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("srwh assertion failed");
`else
`define SRWH_ASSERT(lbl, prop)
`define SRWH_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[rtl/core/srwh_pkg.sv]
// shared constants and types for the shoebox ray wall hit unit
// no dependencies
package srwh_pkg;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned HEAD_W = 18;
  localparam int unsigned STEP_W = 27;
  localparam int unsigned WALL_W = 3;
  localparam int unsigned T_LIMIT = 1000;

  localparam logic [1:0] CFG_LENGTH = 2'd0;
  localparam logic [1:0] CFG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [WALL_W-1:0] WALL_X_LO = 3'd0;
  localparam logic [WALL_W-1:0] WALL_X_HI = 3'd1;
  localparam logic [WALL_W-1:0] WALL_Y_LO = 3'd2;
  localparam logic [WALL_W-1:0] WALL_Y_HI = 3'd3;
  localparam logic [WALL_W-1:0] WALL_Z_LO = 3'd4;
  localparam logic [WALL_W-1:0] WALL_Z_HI = 3'd5;

  // per-ray info that rides alongside the dividers
  typedef struct packed {
    logic [2:0]             nz;
    logic [2:0]             neg;
    logic [2:0]             ok;
    logic [2:0][HEAD_W-1:0] mag;
  } side_t;
endpackage

[rtl/core/shoebox_ray_wall_hit_unit.sv]
// Shoebox ray wall hit unit: finds the first wall of a rectangular room hit by a ray and the
// displacement to it. Accepts one transaction per cycle unless the output stalls, through three
// pipelined dividers retiring one quotient bit per stage. A stall at the output holds the whole
// pipeline. Depends on srwh_pkg, srwh_div and assert_macros.svh.
`include "assert_macros.svh"
module shoebox_ray_wall_hit_unit #(
  parameter int unsigned FracBits = srwh_pkg::FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [23:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, heading_x, heading_y, heading_z, zero pad
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // wall_index, hit_found, step_x, step_y, step_z, zero pad
  output logic [87:0]  m_axis_tdata
);
  localparam int unsigned CW = srwh_pkg::COORD_W;
  localparam int unsigned HW = srwh_pkg::HEAD_W;
  localparam int unsigned SW = srwh_pkg::STEP_W;
  localparam int unsigned DivW = CW + FracBits;
  localparam int unsigned ProdW = DivW + HW;
  localparam int unsigned ShW = ProdW - FracBits;
  localparam logic [DivW-1:0] TLimit = DivW'(srwh_pkg::T_LIMIT) << FracBits;
  localparam logic [ShW-1:0] PosMax = ShW'((64'd1 << (SW - 1)) - 64'd1);

  logic [CW-1:0] length_q, width_q, height_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= 24'd327680;
      width_q  <= 24'd327680;
      height_q <= 24'd196608;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srwh_pkg::CFG_LENGTH: length_q <= cfg_wdata_i;
        srwh_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
        srwh_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_v_q;
  assign adv = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  // input stage: wall distance and heading magnitude per axis
  logic [CW-1:0] org [3];
  logic [CW-1:0] ext [3];
  logic [HW-1:0] head [3];
  logic [CW-1:0] dist_d [3];
  logic [CW-1:0] dist_q [3];
  srwh_pkg::side_t side_d, side0_q;
  logic v0_q;

  assign org[0] = s_axis_tdata[23:0];
  assign org[1] = s_axis_tdata[47:24];
  assign org[2] = s_axis_tdata[71:48];
  assign head[0] = s_axis_tdata[89:72];
  assign head[1] = s_axis_tdata[107:90];
  assign head[2] = s_axis_tdata[125:108];
  assign ext[0] = length_q;
  assign ext[1] = width_q;
  assign ext[2] = height_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side_d.neg[i] = head[i][HW-1];
      side_d.mag[i] = head[i][HW-1] ? HW'(~head[i] + 1'b1) : head[i];
      side_d.nz[i]  = head[i] != '0;
      side_d.ok[i]  = (head[i] != '0) && (head[i][HW-1] || ext[i] > org[i]);
      dist_d[i]     = head[i][HW-1] ? org[i] : CW'(ext[i] - org[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= s_axis_tvalid;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side0_q <= side_d;
      for (int i = 0; i < 3; i++) dist_q[i] <= dist_d[i];
    end
  end

  logic [DivW-1:0] quot [3];
  for (genvar a = 0; a < 3; a++) begin : g_div
    srwh_div #(.DivW(DivW)) u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  ({dist_q[a], FracBits'(0)}),
      .den_i  (side0_q.mag[a]),
      .quot_o (quot[a])
    );
  end

  // side info delay line matching the divider depth
  srwh_pkg::side_t side_pipe_q [DivW];
  logic [DivW-1:0] v_pipe_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_pipe_q <= '0;
    else if (adv) v_pipe_q <= {v_pipe_q[DivW-2:0], v0_q};
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_pipe_q[0] <= side0_q;
      for (int s = 1; s < DivW; s++) side_pipe_q[s] <= side_pipe_q[s-1];
    end
  end

  // wall selection
  srwh_pkg::side_t sd;
  logic [DivW-1:0] best_d, best_q;
  logic [2:0] wall_d, wall_q;
  logic found_d, found_q, v1_q;
  logic [2:0][HW-1:0] mag1_q;
  logic [2:0] neg1_q;
  assign sd = side_pipe_q[DivW-1];

  always_comb begin
    best_d  = TLimit;
    wall_d  = srwh_pkg::WALL_X_LO;
    found_d = 1'b0;
    if (sd.nz[0]) begin
      if (sd.ok[0] && quot[0] != '0) best_d = quot[0];
      wall_d  = sd.neg[0] ? srwh_pkg::WALL_X_LO : srwh_pkg::WALL_X_HI;
      found_d = 1'b1;
    end
    if (sd.ok[1] && quot[1] != '0 && quot[1] < best_d) begin
      best_d  = quot[1];
      wall_d  = sd.neg[1] ? srwh_pkg::WALL_Y_LO : srwh_pkg::WALL_Y_HI;
      found_d = 1'b1;
    end
    if (sd.ok[2] && quot[2] != '0 && quot[2] < best_d) begin
      best_d  = quot[2];
      wall_d  = sd.neg[2] ? srwh_pkg::WALL_Z_LO : srwh_pkg::WALL_Z_HI;
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= v_pipe_q[DivW-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      best_q  <= best_d;
      wall_q  <= wall_d;
      found_q <= found_d;
      mag1_q  <= sd.mag;
      neg1_q  <= sd.neg;
    end
  end

  // scale by heading magnitude
  logic [ProdW-1:0] prod_q [3];
  logic [2:0] wall2_q;
  logic found2_q, v2_q;
  logic [2:0] neg2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) prod_q[i] <= ProdW'(best_q) * ProdW'(mag1_q[i]);
      wall2_q  <= wall_q;
      found2_q <= found_q;
      neg2_q   <= neg1_q;
    end
  end

  // truncate, restore sign and saturate
  logic [ShW-1:0] sh [3];
  logic [SW-1:0] step_d [3];
  logic [SW-1:0] step_q [3];
  logic [2:0] wall_o_q;
  logic found_o_q;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = prod_q[i][ProdW-1:FracBits];
      if (neg2_q[i]) begin
        step_d[i] = (sh[i] > PosMax) ? {1'b1, {(SW-1){1'b0}}} : SW'(~sh[i] + 1'b1);
      end else begin
        step_d[i] = (sh[i] > PosMax) ? SW'(PosMax) : SW'(sh[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) step_q[i] <= step_d[i];
      wall_o_q  <= found2_q ? wall2_q : srwh_pkg::WALL_X_LO;
      found_o_q <= found2_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {3'b000, step_q[2], step_q[1], step_q[0], found_o_q, wall_o_q};

  `SRWH_ASSERT(a_wall_range, out_v_q |-> (wall_o_q <= srwh_pkg::WALL_Z_HI))
  `SRWH_ASSERT(a_nohit_wall, (out_v_q && !found_o_q) |-> (wall_o_q == srwh_pkg::WALL_X_LO))
  `SRWH_ASSERT_NEXT(a_stall_holds, !adv, out_v_q && $stable(v2_q))
endmodule

[rtl/core/srwh_div.sv]
// pipelined restoring divider, one quotient bit per stage
// depends on srwh_pkg
module srwh_div #(
  parameter int unsigned DivW = 40
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [DivW-1:0]             num_i,
  input  logic [srwh_pkg::HEAD_W-1:0] den_i,
  output logic [DivW-1:0]             quot_o
);
  localparam int unsigned DenW = srwh_pkg::HEAD_W;

  logic [DivW-1:0] num_q [DivW];
  logic [DenW-1:0] rem_q [DivW];
  logic [DenW-1:0] den_q [DivW];

  for (genvar s = 0; s < DivW; s++) begin : g_stage
    logic [DivW-1:0] num_in;
    logic [DenW-1:0] rem_in;
    logic [DenW-1:0] den_in;
    logic [DenW:0]   trial;
    logic            ge;
    if (s == 0) begin : g_first
      assign num_in = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign num_in = num_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
    end
    assign trial = {rem_in, num_in[DivW-1]};
    assign ge = trial >= {1'b0, den_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // quotient bits shift in from the bottom as numerator bits leave the top
        num_q[s] <= {num_in[DivW-2:0], ge};
        rem_q[s] <= ge ? DenW'(trial - {1'b0, den_in}) : DenW'(trial);
        den_q[s] <= den_in;
      end
    end
  end

  assign quot_o = num_q[DivW-1];
endmodule

[verif/shoebox_ray_wall_hit_unit_tb.sv]
// testbench for the shoebox ray wall hit unit: random and corner rays checked against a
// behavioral predictor of the wall choice and the saturated displacement
// depends on srwh_pkg and the shoebox_ray_wall_hit_unit rtl
`timescale 1ns / 100ps
module shoebox_ray_wall_hit_unit_tb;

  localparam int LATENCY = 24 + srwh_pkg::FRAC_BITS + 4;

  typedef struct packed {
    logic [2:0]  wall;
    logic        hit;
    logic [26:0] sx;
    logic [26:0] sy;
    logic [26:0] sz;
  } hit_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [23:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;

  logic [23:0] room_len = 24'd327680, room_wid = 24'd327680, room_hgt = 24'd196608;
  hit_t        hits_pending[$];
  int          errors = 0;
  int          send_idle_pct = 17;
  bit          recv_idle_on = 1'b1;
  bit          recv_hold = 1'b0;

  shoebox_ray_wall_hit_unit dut (.*);

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #8000000;
    $display("Verification failed");
    $finish;
  end

  // travel parameter along one axis; returns 0 when non-positive
  function automatic bit axis_t(logic [23:0] org, logic [23:0] ext, logic signed [17:0] h,
                                output logic [63:0] t);
    logic [63:0] span, mag;
    if (h < 0) begin
      span = org;
      mag = -64'(h);
    end else begin
      if (ext <= org) begin
        t = 0;
        return 0;
      end
      span = ext - org;
      mag = 64'(h);
    end
    t = (span << srwh_pkg::FRAC_BITS) / mag;
    return t > 0;
  endfunction

  function automatic logic [26:0] scaled_step(logic [63:0] t, logic signed [17:0] h);
    logic [127:0] prod;
    logic [63:0]  mag;
    mag = h < 0 ? -64'(h) : 64'(h);
    prod = (128'(t) * 128'(mag)) >> srwh_pkg::FRAC_BITS;
    if (mag == 0) return '0;
    if (h < 0) return prod >= 128'd67108864 ? 27'h4000000 : 27'(-prod);
    return prod > 128'd67108863 ? 27'h3FFFFFF : 27'(prod);
  endfunction

  function automatic hit_t predict_hit(logic [127:0] d);
    logic [23:0] ox, oy, oz;
    logic signed [17:0] hx, hy, hz;
    logic [63:0] best, t;
    hit_t r;
    ox = d[23:0]; oy = d[47:24]; oz = d[71:48];
    hx = d[89:72]; hy = d[107:90]; hz = d[125:108];
    best = 64'(srwh_pkg::T_LIMIT) << srwh_pkg::FRAC_BITS;
    r = '0;
    if (hx != 0) begin
      if (axis_t(ox, room_len, hx, t)) best = t;
      r.wall = hx < 0 ? srwh_pkg::WALL_X_LO : srwh_pkg::WALL_X_HI;
      r.hit = 1'b1;
    end
    if (hy != 0 && axis_t(oy, room_wid, hy, t) && t < best) begin
      best = t;
      r.wall = hy < 0 ? srwh_pkg::WALL_Y_LO : srwh_pkg::WALL_Y_HI;
      r.hit = 1'b1;
    end
    if (hz != 0 && axis_t(oz, room_hgt, hz, t) && t < best) begin
      best = t;
      r.wall = hz < 0 ? srwh_pkg::WALL_Z_LO : srwh_pkg::WALL_Z_HI;
      r.hit = 1'b1;
    end
    if (!r.hit) r.wall = srwh_pkg::WALL_X_LO;
    r.sx = scaled_step(best, hx);
    r.sy = scaled_step(best, hy);
    r.sz = scaled_step(best, hz);
    return r;
  endfunction

  // leaves tvalid high after the transaction; idle cycles in the next call or drain take it down
  task automatic send_ray(logic [23:0] ox, oy, oz, logic [17:0] hx, hy, hz);
    logic [127:0] d;
    d = {2'b0, hz, hy, hx, oz, oy, ox};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    hits_pending.push_back(predict_hit(d));
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (hits_pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic write_room(logic [1:0] idx, logic [23:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      srwh_pkg::CFG_LENGTH: room_len = v;
      srwh_pkg::CFG_WIDTH:  room_wid = v;
      srwh_pkg::CFG_HEIGHT: room_hgt = v;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic logic [17:0] rand_head();
    case ($urandom_range(5))
      0: return 18'h10000;
      1: return 18'h30000;
      2: return 18'd0;
      3: return 18'($urandom);
      default: return 18'($signed($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic logic [23:0] rand_origin(logic [23:0] ext);
    case ($urandom_range(5))
      0: return 24'($urandom);
      1: return ext;
      default: return 24'($urandom_range(ext));
    endcase
  endfunction

  task automatic send_random_ray();
    send_ray(rand_origin(room_len), rand_origin(room_wid), rand_origin(room_hgt),
             rand_head(), rand_head(), rand_head());
  endtask

  task automatic test_directed();
    send_ray(24'd0, 24'd0, 24'd0, 18'd0, 18'd0, 18'd0);           // zero heading
    send_ray(24'd65536, 24'd65536, 24'd65536, 18'h10000, 18'd0, 18'd0);
    send_ray(24'd65536, 24'd65536, 24'd65536, 18'h30000, 18'd0, 18'd0);
    send_ray(24'd65536, 24'd65536, 24'd65536, 18'd0, 18'h10000, 18'd0);
    send_ray(24'd65536, 24'd65536, 24'd65536, 18'd0, 18'h30000, 18'd0);
    send_ray(24'd65536, 24'd65536, 24'd65536, 18'd0, 18'd0, 18'h10000);
    send_ray(24'd65536, 24'd65536, 24'd65536, 18'd0, 18'd0, 18'h30000);
    send_ray(24'd65536, 24'd65536, 24'd65536, 18'd1000, 18'd2000, 18'd3000);
    // origin outside the room, x param non-positive
    send_ray(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
    send_ray(24'd0, 24'd100, 24'd100, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    // tiny and extreme headings; only the last of these rays saturates the displacement
    send_ray(24'd0, 24'd0, 24'd0, 18'd1, 18'd1, 18'd1);
    send_ray(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    send_ray(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 18'h20000, 18'h20000, 18'h20000);
    send_ray(24'hFFFFFF, 24'h0, 24'hFFFFFF, 18'h1FFFF, 18'h20000, 18'h1FFFF);
    // parameter truncating to zero
    send_ray(24'd327679, 24'd10, 24'd10, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF);
  endtask

  task automatic test_registers();
    logic [23:0] vals[5] = '{24'd1, 24'hFFFFFF, 24'd0, 24'd65536, 24'd2000000};
    foreach (vals[i]) begin
      drain();
      write_room(srwh_pkg::CFG_LENGTH, vals[i]);
      write_room(srwh_pkg::CFG_WIDTH, vals[(i + 1) % 5]);
      write_room(srwh_pkg::CFG_HEIGHT, vals[(i + 2) % 5]);
      write_room(2'd3, 24'($urandom));  // unmapped index, ignored
      repeat (60) send_random_ray();
    end
    drain();
    write_room(srwh_pkg::CFG_LENGTH, 24'd327680);
    write_room(srwh_pkg::CFG_WIDTH, 24'd327680);
    write_room(srwh_pkg::CFG_HEIGHT, 24'd196608);
  endtask

  task automatic test_random();
    repeat (1200) send_random_ray();
    send_idle_pct = 0;
    recv_idle_on = 1'b0;
    repeat (300) send_random_ray();
    send_idle_pct = 17;
    recv_idle_on = 1'b1;
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_hold = 1'b1;
    repeat (200) send_random_ray();
    send_idle_pct = 17;
  endtask

  // long receiver hold-off counted in its own process
  initial begin
    int cnt;
    cnt = 0;
    forever begin
      @(negedge clk_i);
      if (recv_hold) begin
        cnt++;
        if (cnt == 300) begin
          recv_hold = 1'b0;
          cnt = 0;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= !recv_hold && !(recv_idle_on && $urandom_range(99) < 17);
    end
  end

  initial begin
    hit_t got, want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.wall = m_axis_tdata[2:0];
        got.hit = m_axis_tdata[3];
        got.sx = m_axis_tdata[30:4];
        got.sy = m_axis_tdata[57:31];
        got.sz = m_axis_tdata[84:58];
        if (hits_pending.size() == 0) begin
          $display("%t: unexpected transaction %h", $time, m_axis_tdata);
          errors++;
        end else begin
          want = hits_pending.pop_front();
          if (got.wall !== want.wall) begin
            $display("%t: wall exp %0d got %0d", $time, want.wall, got.wall);
            errors++;
          end
          if (got.hit !== want.hit) begin
            $display("%t: hit exp %0d got %0d", $time, want.hit, got.hit);
            errors++;
          end
          if (got.sx !== want.sx) begin
            $display("%t: step_x exp %h got %h", $time, want.sx, got.sx);
            errors++;
          end
          if (got.sy !== want.sy) begin
            $display("%t: step_y exp %h got %h", $time, want.sy, got.sy);
            errors++;
          end
          if (got.sz !== want.sz) begin
            $display("%t: step_z exp %h got %h", $time, want.sz, got.sz);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_backpressure();
    test_registers();
    test_random();
    drain();
    if (errors == 0 && hits_pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
